### design/imusc_pkg.sv
// Package for the IMU sample conditioning block: channel constants, register
// indexes and the structs passed between the register file, lanes and merge.
// No dependencies.
`timescale 1ns / 1ps

package imusc_pkg;

    localparam int NUM_CH   = 6;
    localparam int NUM_GYRO = 3;
    localparam int NUM_ACC  = NUM_CH - NUM_GYRO;

    localparam int RAW_W    = 12;
    localparam int OFF_W    = 16;
    localparam int LIM_W    = 15;
    localparam int GAIN_W   = 16;
    localparam int OUT_W    = 24;
    localparam int CNT_W    = 16;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 6;

    localparam logic [RAW_W-1:0] GYRO_BIAS  = 12'd1658;
    localparam logic [RAW_W-1:0] ACCEL_BIAS = 12'd2041;

    localparam logic [NUM_CH-1:0][RAW_W-1:0] CH_BIAS =
        {ACCEL_BIAS, ACCEL_BIAS, ACCEL_BIAS, GYRO_BIAS, GYRO_BIAS, GYRO_BIAS};

    // orientation: gyro y, gyro z and accel x are reversed
    localparam logic [NUM_CH-1:0] CH_NEGATE = 6'b001110;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd14400;

    localparam logic [2:0] REG_GYRO_OFF_X  = 3'd0;
    localparam logic [2:0] REG_GYRO_OFF_Y  = 3'd1;
    localparam logic [2:0] REG_GYRO_OFF_Z  = 3'd2;
    localparam logic [2:0] REG_ACCEL_OFF_X = 3'd3;
    localparam logic [2:0] REG_ACCEL_OFF_Y = 3'd4;
    localparam logic [2:0] REG_ACCEL_OFF_Z = 3'd5;
    localparam logic [2:0] REG_CLAMP_LIMIT = 3'd6;
    localparam logic [2:0] REG_GAIN_WORDS  = 3'd7;

    typedef struct packed {
        logic [NUM_CH-1:0][OFF_W-1:0] offset;
        logic [LIM_W-1:0]             limit;
        logic [DATA_W-1:0]            gain_words;
    } cfg_t;

    typedef struct packed {
        logic              negate;
        logic [RAW_W-1:0]  bias;
        logic [OFF_W-1:0]  offset;
        logic [GAIN_W-1:0] gain;
        logic [LIM_W-1:0]  limit;
    } lane_cfg_t;

    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } adv_t;

endpackage

### design/imusc_regs.sv
// APB-style configuration registers of the IMU sample conditioning block.
// Depends on imusc_pkg.
`timescale 1ns / 1ps

module imusc_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [imusc_pkg::ADDR_W-1:0] paddr,
    input  logic [imusc_pkg::DATA_W-1:0] pwdata,
    output logic [imusc_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output imusc_pkg::cfg_t              cfg
);

    imusc_pkg::cfg_t cfg_reg;
    imusc_pkg::cfg_t cfg_next;
    logic [2:0]      idx;
    logic            wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[imusc_pkg::ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                imusc_pkg::REG_GYRO_OFF_X:  cfg_next.offset[0] = pwdata[15:0];
                imusc_pkg::REG_GYRO_OFF_Y:  cfg_next.offset[1] = pwdata[15:0];
                imusc_pkg::REG_GYRO_OFF_Z:  cfg_next.offset[2] = pwdata[15:0];
                imusc_pkg::REG_ACCEL_OFF_X: cfg_next.offset[3] = pwdata[15:0];
                imusc_pkg::REG_ACCEL_OFF_Y: cfg_next.offset[4] = pwdata[15:0];
                imusc_pkg::REG_ACCEL_OFF_Z: cfg_next.offset[5] = pwdata[15:0];
                imusc_pkg::REG_CLAMP_LIMIT: cfg_next.limit     = pwdata[14:0];
                imusc_pkg::REG_GAIN_WORDS:  cfg_next.gain_words = pwdata;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            imusc_pkg::REG_GYRO_OFF_X:  prdata = {48'd0, cfg_reg.offset[0]};
            imusc_pkg::REG_GYRO_OFF_Y:  prdata = {48'd0, cfg_reg.offset[1]};
            imusc_pkg::REG_GYRO_OFF_Z:  prdata = {48'd0, cfg_reg.offset[2]};
            imusc_pkg::REG_ACCEL_OFF_X: prdata = {48'd0, cfg_reg.offset[3]};
            imusc_pkg::REG_ACCEL_OFF_Y: prdata = {48'd0, cfg_reg.offset[4]};
            imusc_pkg::REG_ACCEL_OFF_Z: prdata = {48'd0, cfg_reg.offset[5]};
            imusc_pkg::REG_CLAMP_LIMIT: prdata = {49'd0, cfg_reg.limit};
            imusc_pkg::REG_GAIN_WORDS:  prdata = cfg_reg.gain_words;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset     <= '0;
            cfg_reg.limit      <= imusc_pkg::LIMIT_RESET;
            cfg_reg.gain_words <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/imusc_lane.sv
// One channel lane: bias removal, orientation against offset, clamp, then
// gain multiply; two register stages. Depends on imusc_pkg.
`timescale 1ns / 1ps

module imusc_lane (
    input  logic                              aclk,
    input  imusc_pkg::adv_t                   adv,
    input  imusc_pkg::lane_cfg_t              lcfg,
    input  logic [imusc_pkg::RAW_W-1:0]       raw,
    output logic signed [imusc_pkg::OUT_W-1:0] scaled,
    output logic                              hit
);

    logic signed [12:0] diff;
    logic signed [16:0] reading;
    logic signed [17:0] rd_ext;
    logic signed [17:0] off_ext;
    logic signed [17:0] corr;
    logic signed [17:0] lim_pos;
    logic signed [17:0] lim_neg;
    logic               over;
    logic               under;
    logic signed [15:0] clamp_next;
    logic signed [15:0] clamp_reg;
    logic               hit1_reg;
    logic signed [32:0] prod;
    logic signed [imusc_pkg::OUT_W-1:0] scaled_reg;
    logic               hit2_reg;

    assign diff    = $signed({1'b0, raw} - {1'b0, lcfg.bias});
    assign reading = {diff, 4'b0000};
    assign rd_ext  = 18'(reading);
    assign off_ext = 18'($signed(lcfg.offset));
    assign corr    = lcfg.negate ? (off_ext - rd_ext) : (rd_ext - off_ext);
    assign lim_pos = $signed({3'b000, lcfg.limit});
    assign lim_neg = -lim_pos;
    assign over    = corr > lim_pos;
    assign under   = corr < lim_neg;

    always_comb begin
        priority if (over) begin
            clamp_next = lim_pos[15:0];
        end else if (under) begin
            clamp_next = lim_neg[15:0];
        end else begin
            clamp_next = corr[15:0];
        end
    end

    assign prod = clamp_reg * $signed({1'b0, lcfg.gain});

    always_ff @(posedge aclk) begin
        if (adv.load1) begin
            clamp_reg <= clamp_next;
            hit1_reg  <= over || under;
        end
        if (adv.load2) begin
            scaled_reg <= prod[31:8];
            hit2_reg   <= hit1_reg;
        end
    end

    assign scaled = scaled_reg;
    assign hit    = hit2_reg;

endmodule

### design/imusc_merge.sv
// Merge stage: output word register, halving average of the accelerometer
// lanes and the saturating clamp counter. Depends on imusc_pkg.
`timescale 1ns / 1ps

module imusc_merge (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 load,
    input  logic [imusc_pkg::NUM_CH-1:0][imusc_pkg::OUT_W-1:0]   scaled,
    input  logic [imusc_pkg::NUM_CH-1:0]                         hit,
    output logic [imusc_pkg::NUM_CH-1:0][imusc_pkg::OUT_W-1:0]   scaled_out,
    output logic [imusc_pkg::NUM_ACC-1:0][imusc_pkg::OUT_W-1:0]  smooth,
    output logic [imusc_pkg::CNT_W-1:0]                          total
);

    logic [imusc_pkg::NUM_CH-1:0][imusc_pkg::OUT_W-1:0]  scaled_reg;
    logic [imusc_pkg::NUM_ACC-1:0][imusc_pkg::OUT_W-1:0] smooth_reg;
    logic [imusc_pkg::NUM_ACC-1:0][imusc_pkg::OUT_W-1:0] smooth_next;
    logic [imusc_pkg::CNT_W-1:0]                         total_reg;
    logic [imusc_pkg::CNT_W-1:0]                         total_next;
    logic [2:0]                                          n_hits;
    logic [imusc_pkg::CNT_W:0]                           total_sum;

    always_comb begin
        logic [imusc_pkg::OUT_W:0] sum;
        for (int a = 0; a < imusc_pkg::NUM_ACC; a++) begin
            sum = {smooth_reg[a][imusc_pkg::OUT_W-1], smooth_reg[a]}
                + {scaled[imusc_pkg::NUM_GYRO + a][imusc_pkg::OUT_W-1],
                   scaled[imusc_pkg::NUM_GYRO + a]};
            smooth_next[a] = sum[imusc_pkg::OUT_W:1];
        end
    end

    assign n_hits     = 3'($countones(hit));
    assign total_sum  = {1'b0, total_reg} + (imusc_pkg::CNT_W + 1)'(n_hits);
    assign total_next = total_sum[imusc_pkg::CNT_W] ? '1 : total_sum[imusc_pkg::CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            scaled_reg <= scaled;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= '0;
            total_reg  <= '0;
        end else if (load) begin
            smooth_reg <= smooth_next;
            total_reg  <= total_next;
        end
    end

    assign scaled_out = scaled_reg;
    assign smooth     = smooth_reg;
    assign total      = total_reg;

endmodule

### design/imu_sample_conditioning.sv
// Top level of the IMU sample conditioning block: six lanes, merge stage,
// register file and pipeline handshake. Depends on imusc_pkg and all imusc_ modules.
//
// channel  | direction | handshake          | payload
// s_       | in        | s_valid / s_ready  | six raw 12-bit readings
// m_       | out       | m_valid / m_ready  | rate, acc, smooth, clamp_total
// apb      | in        | psel/penable/pready| 64-bit registers at 8*index
//
// Three register stages (clamp, multiply, merge); m_valid is the merge stage valid.
// One word per cycle while m_ready is high; each stage holds its own word.
// Reset clears pipeline valids, filter, counter, offsets, gains; limit goes to 14400.
// A stall on m_ready backs up stage by stage; s_ready drops only with all three full.
`timescale 1ns / 1ps

module imu_sample_conditioning (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [imusc_pkg::ADDR_W-1:0]        paddr,
    input  logic [imusc_pkg::DATA_W-1:0]        pwdata,
    output logic [imusc_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [imusc_pkg::RAW_W-1:0]         s_raw_gyro_x,
    input  logic [imusc_pkg::RAW_W-1:0]         s_raw_gyro_y,
    input  logic [imusc_pkg::RAW_W-1:0]         s_raw_gyro_z,
    input  logic [imusc_pkg::RAW_W-1:0]         s_raw_accel_x,
    input  logic [imusc_pkg::RAW_W-1:0]         s_raw_accel_y,
    input  logic [imusc_pkg::RAW_W-1:0]         s_raw_accel_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [imusc_pkg::OUT_W-1:0]  m_rate_x,
    output logic signed [imusc_pkg::OUT_W-1:0]  m_rate_y,
    output logic signed [imusc_pkg::OUT_W-1:0]  m_rate_z,
    output logic signed [imusc_pkg::OUT_W-1:0]  m_acc_x,
    output logic signed [imusc_pkg::OUT_W-1:0]  m_acc_y,
    output logic signed [imusc_pkg::OUT_W-1:0]  m_acc_z,
    output logic signed [imusc_pkg::OUT_W-1:0]  m_smooth_x,
    output logic signed [imusc_pkg::OUT_W-1:0]  m_smooth_y,
    output logic signed [imusc_pkg::OUT_W-1:0]  m_smooth_z,
    output logic [imusc_pkg::CNT_W-1:0]         m_clamp_total
);

    imusc_pkg::cfg_t                                     cfg;
    imusc_pkg::adv_t                                     adv;
    logic [imusc_pkg::NUM_CH-1:0][imusc_pkg::RAW_W-1:0]  raw;
    logic [imusc_pkg::NUM_CH-1:0][imusc_pkg::OUT_W-1:0]  scaled;
    logic [imusc_pkg::NUM_CH-1:0]                        hit;
    logic [imusc_pkg::NUM_CH-1:0][imusc_pkg::OUT_W-1:0]  scaled_out;
    logic [imusc_pkg::NUM_ACC-1:0][imusc_pkg::OUT_W-1:0] smooth;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic ready1;
    logic ready2;
    logic ready3;

    assign raw = {s_raw_accel_z, s_raw_accel_y, s_raw_accel_x,
                  s_raw_gyro_z, s_raw_gyro_y, s_raw_gyro_x};

    assign ready3    = !v3_reg || m_ready;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign s_ready   = ready1;
    assign adv.load1 = ready1 && s_valid;
    assign adv.load2 = ready2 && v1_reg;
    assign adv.load3 = ready3 && v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) v1_reg <= s_valid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
        end
    end

    imusc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    for (genvar ch = 0; ch < imusc_pkg::NUM_CH; ch++) begin : g_lane
        localparam int SLOT = (ch < imusc_pkg::NUM_GYRO) ? ch : imusc_pkg::NUM_GYRO;
        imusc_pkg::lane_cfg_t lcfg;

        assign lcfg.negate = imusc_pkg::CH_NEGATE[ch];
        assign lcfg.bias   = imusc_pkg::CH_BIAS[ch];
        assign lcfg.offset = cfg.offset[ch];
        assign lcfg.gain   = cfg.gain_words[imusc_pkg::GAIN_W*SLOT +: imusc_pkg::GAIN_W];
        assign lcfg.limit  = cfg.limit;

        imusc_lane u_lane (
            .aclk   (aclk),
            .adv    (adv),
            .lcfg   (lcfg),
            .raw    (raw[ch]),
            .scaled (scaled[ch]),
            .hit    (hit[ch])
        );
    end

    imusc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (adv.load3),
        .scaled     (scaled),
        .hit        (hit),
        .scaled_out (scaled_out),
        .smooth     (smooth),
        .total      (m_clamp_total)
    );

    assign m_valid    = v3_reg;
    assign m_rate_x   = scaled_out[0];
    assign m_rate_y   = scaled_out[1];
    assign m_rate_z   = scaled_out[2];
    assign m_acc_x    = scaled_out[3];
    assign m_acc_y    = scaled_out[4];
    assign m_acc_z    = scaled_out[5];
    assign m_smooth_x = smooth[0];
    assign m_smooth_y = smooth[1];
    assign m_smooth_z = smooth[2];

`ifndef SYNTH
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && !m_ready))
        else $error("input stalled with a free stage");

    a_accept_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted word not held in first stage");

    a_mid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !ready3) |=> v2_reg)
        else $error("word lost in multiply stage");

    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        adv.load3 |=> (m_clamp_total >= $past(m_clamp_total)))
        else $error("clamp counter went backwards");
`endif

endmodule
